// ----- rtl/rbe_pkg.sv -----
// Shared types and constants for the Rice byte encoder.
package rbe_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [2:0]  RICE_K_RESET = 3'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] ones_cnt;
      logic [7:0] tail_bits;
      logic [3:0] tail_len;
      logic [8:0] code_len;
      logic       last;
   } cmd_type;

endpackage

// ----- rtl/rbe_front.sv -----
// Front end: holds rice_k, accepts requests and splits each byte into unary run and tail.
module rbe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbe_pkg::req_type req_payload,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output rbe_pkg::cmd_type cmd_data
);
   import rbe_pkg::*;

   logic [2:0] rice_k_ff;
   logic [2:0] rice_k_in;
   logic [7:0] quotient;
   logic [7:0] tail;

   assign rice_k_in = csr_wr_en ? csr_wr_data : rice_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rice_k_ff <= RICE_K_RESET;
      end else begin
         rice_k_ff <= rice_k_in;
      end
   end

   assign quotient = req_payload.data_byte >> rice_k_ff;

   // tail bits in packing order: stop bit first, then remainder msb first
   always_comb begin
      tail = 8'h00;
      for (int j = 1; j < 8; j++) begin
         if (3'(j) <= rice_k_ff) begin
            tail[j] = req_payload.data_byte[rice_k_ff - 3'(j)];
         end
      end
   end

   assign req_ready          = cmd_ready;
   assign cmd_valid          = req_valid;
   assign cmd_data.ones_cnt  = quotient;
   assign cmd_data.tail_bits = tail;
   assign cmd_data.tail_len  = {1'b0, rice_k_ff} + 4'd1;
   assign cmd_data.code_len  = {1'b0, quotient} + {6'd0, rice_k_ff} + 9'd1;
   assign cmd_data.last      = req_payload.last_byte;

endmodule

// ----- rtl/rbe_queue.sv -----
// Short command queue between the front end and the bit packer.
module rbe_queue #(
   parameter int unsigned Depth = rbe_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rbe_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output rbe_pkg::cmd_type pop_data
);
   import rbe_pkg::*;

   localparam int unsigned AddrWidth  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   cmd_type               entries_ff [Depth];
   logic [AddrWidth-1:0]  wr_ptr_ff;
   logic [AddrWidth-1:0]  wr_ptr_in;
   logic [AddrWidth-1:0]  rd_ptr_ff;
   logic [AddrWidth-1:0]  rd_ptr_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = (count_ff != CountWidth'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AddrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/rbe_back.sv -----
// Back end: packs unary runs and tails into bytes and drives the response register.
module rbe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  rbe_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbe_pkg::rsp_type rsp_payload
);
   import rbe_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ONES  = 4'b0010,
      ST_TAIL  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  acc_ff, acc_in;
   logic [2:0]  fill_ff, fill_in;
   logic [7:0]  ones_left_ff, ones_left_in;
   logic [7:0]  tail_bits_ff, tail_bits_in;
   logic [3:0]  tail_len_ff, tail_len_in;
   logic        last_ff, last_in;
   logic [5:0]  remaining_ff, remaining_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        can_emit;
   logic        emit;
   logic [7:0]  chunk;
   logic [3:0]  chunk_len;
   logic [8:0]  ones_mask;
   logic [15:0] merged;
   logic [3:0]  fill_sum;
   logic [8:0]  end_bits;
   logic        pad;

   assign can_emit = !rsp_valid_ff || rsp_ready;

   assign end_bits = {6'd0, fill_ff} + cmd_data.code_len;
   assign pad      = cmd_data.last && (end_bits[2:0] != 3'd0);

   always_comb begin
      if (ones_left_ff >= 8'd8) begin
         chunk_len = 4'd8;
      end else begin
         chunk_len = {1'b0, ones_left_ff[2:0]};
      end
      ones_mask = 9'((9'd1 << chunk_len) - 9'd1);
      if (state_ff == ST_TAIL) begin
         chunk     = tail_bits_ff;
         chunk_len = tail_len_ff;
      end else begin
         chunk = ones_mask[7:0];
      end
   end

   assign merged   = {8'h00, acc_ff} | 16'({8'h00, chunk} << fill_ff);
   assign fill_sum = {1'b0, fill_ff} + chunk_len;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      fill_in      = fill_ff;
      ones_left_in = ones_left_ff;
      tail_bits_in = tail_bits_ff;
      tail_len_in  = tail_len_ff;
      last_in      = last_ff;
      remaining_in = remaining_ff;
      rsp_data_in  = rsp_data_ff;
      emit         = 1'b0;
      cmd_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               ones_left_in = cmd_data.ones_cnt;
               tail_bits_in = cmd_data.tail_bits;
               tail_len_in  = cmd_data.tail_len;
               last_in      = cmd_data.last;
               remaining_in = end_bits[8:3] + {5'd0, pad};
               state_in     = (cmd_data.ones_cnt != 8'd0) ? ST_ONES : ST_TAIL;
            end
         end
         ST_ONES, ST_TAIL: begin
            if (can_emit) begin
               fill_in = fill_sum[2:0];
               if (fill_sum[3]) begin
                  emit                   = 1'b1;
                  acc_in                 = merged[15:8];
                  rsp_data_in.packed_byte = merged[7:0];
                  rsp_data_in.run_last    = (remaining_ff == 6'd1);
                  rsp_data_in.stream_end  = last_ff && (remaining_ff == 6'd1);
                  remaining_in           = remaining_ff - 6'd1;
               end else begin
                  acc_in = merged[7:0];
               end
               if (state_ff == ST_ONES) begin
                  ones_left_in = ones_left_ff - {4'd0, chunk_len};
                  if (ones_left_ff == {4'd0, chunk_len}) begin
                     state_in = ST_TAIL;
                  end
               end else if (last_ff && (fill_sum[2:0] != 3'd0)) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (can_emit) begin
               emit                    = 1'b1;
               rsp_data_in.packed_byte = acc_ff;
               rsp_data_in.run_last    = 1'b1;
               rsp_data_in.stream_end  = 1'b1;
               acc_in                  = 8'h00;
               fill_in                 = 3'd0;
               remaining_in            = remaining_ff - 6'd1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= 8'h00;
         fill_ff      <= 3'd0;
         remaining_ff <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ones_left_ff <= ones_left_in;
      tail_bits_ff <= tail_bits_in;
      tail_len_ff  <= tail_len_in;
      last_ff      <= last_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ----- rtl/rice_byte_encoder.sv -----
// Top level of the Rice byte encoder with parameter k written through the csr channel.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_ready   | req_payload (data_byte, last_byte)
//  rsp     | out       | rsp_valid / rsp_ready   | rsp_payload (packed_byte, run_last,
//          |           |                         |   stream_end)
//  csr     | in        | csr_wr_en, no wait      | csr_wr_data (rice_k)
//
// The packer takes a request from the queue in ST_IDLE, packs the unary run of q ones in
// ST_ONES (q = data_byte >> rice_k, up to eight ones a cycle while not held), stop bit and
// remainder in ST_TAIL, and a padded byte in ST_FLUSH at the end of a stream that
// leaves bits over. A run of no ones goes straight from ST_IDLE to ST_TAIL.
// Requests are taken while the command queue has room, so the front end runs ahead of
// the packer. The packer holds whenever the response register is full and not drained.
// Reset (synchronous) empties the queue and the packer and sets rice_k to 1.
module rice_byte_encoder #(
   parameter int unsigned QueueDepth = rbe_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbe_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbe_pkg::rsp_type rsp_payload
);
   import rbe_pkg::*;

   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;
   logic    back_valid;
   logic    back_ready;
   cmd_type back_cmd;

   rbe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready),
      .cmd_data    (front_cmd)
   );

   rbe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   rbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (back_valid),
      .cmd_ready   (back_ready),
      .cmd_data    (back_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
